// ===== rtl/core/pept_pkg.sv =====
// Shared types and constants for the PWM encoder position tracker.
// No dependencies; every other file in rtl/core imports this package.
package pept_pkg;

    // Fixed field widths
    localparam int POS_W  = 41;
    localparam int POLE_W = 24;
    localparam int INT_W  = 24;
    localparam int LEN_W  = 12;
    localparam int CFG_W  = 24;
    localparam int IDX_W  = 1;

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_INTERVAL = 1'b0;
    localparam logic [IDX_W-1:0] REG_POLE_LEN = 1'b1;

    // Register reset values
    localparam logic [INT_W-1:0] INTERVAL_RST = 24'd100000;
    localparam logic [LEN_W-1:0] POLE_LEN_RST = 12'd2000;

    // One input beat: sampled pin levels for a tick
    typedef struct packed {
        logic pwm_level;
        logic index_level;
    } t_in_beat;

    // One output beat: a position report
    typedef struct packed {
        logic signed [POS_W-1:0]  position;
        logic signed [POLE_W-1:0] pole_total;
        logic                     position_valid;
    } t_out_beat;

    // Report sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_H,
        ST_MUL_C,
        ST_DIV,
        ST_DONE
    } t_state;

    // Controls from the sequencer to the arithmetic unit
    typedef struct packed {
        logic load;
        logic mul_h;
        logic mul_c;
        logic div_step;
        logic out_load;
    } t_arith_ctl;

endpackage

// ===== rtl/core/pept_track.sv =====
// Per-tick front end: PWM edge timing, pole pair counter, report timer,
// configuration registers. Depends on pept_pkg.
module pept_track #(
    parameter int COUNT_BITS = 24,
    parameter int FRAC_BITS  = 4,
    parameter int TIME_BITS  = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_accept,
    input  logic                                     i_pwm,
    input  logic                                     i_idx,
    input  logic                                     i_cfg_we,
    input  logic [pept_pkg::IDX_W-1:0]               i_cfg_idx,
    input  logic [pept_pkg::CFG_W-1:0]               i_cfg_data,
    output logic                                     o_report,
    output logic [TIME_BITS-1:0]                     o_high,
    output logic [TIME_BITS-1:0]                     o_period,
    output logic [COUNT_BITS-1:0]                    o_pole,
    output logic [pept_pkg::LEN_W+FRAC_BITS-1:0]     o_scale
);
    import pept_pkg::*;

    localparam int QW = LEN_W + FRAC_BITS;

    logic [TIME_BITS-1:0]  r_tick, r_last_rise, r_period, r_high;
    logic [TIME_BITS-1:0]  n_last_rise, n_period, n_high, w_diff, w_hcl;
    logic                  r_prev_pwm, r_prev_idx;
    logic [COUNT_BITS-1:0] r_pole, n_pole;
    logic [INT_W-1:0]      r_timer, w_timer_inc;
    logic [INT_W-1:0]      r_interval;
    logic [LEN_W-1:0]      r_pole_len;
    logic                  w_rise, w_fall, w_idx_rise, w_fwd;

    // Edge detection and next state for this tick
    always_comb begin
        w_rise      = i_pwm & ~r_prev_pwm;
        w_fall      = ~i_pwm & r_prev_pwm;
        w_idx_rise  = i_idx & ~r_prev_idx;
        w_diff      = r_tick - r_last_rise;
        n_period    = w_rise ? w_diff : r_period;
        n_last_rise = w_rise ? r_tick : r_last_rise;
        n_high      = w_fall ? w_diff : r_high;
        w_hcl       = (n_high < n_period) ? n_high : n_period;
        w_fwd       = {w_hcl, 1'b0} < {1'b0, n_period};
        n_pole      = r_pole;
        if (w_idx_rise) begin
            n_pole = w_fwd ? r_pole + COUNT_BITS'(1) : r_pole - COUNT_BITS'(1);
        end
        w_timer_inc = r_timer + INT_W'(1);
    end

    // Report due when the bumped timer reaches the interval
    assign o_report = (w_timer_inc >= r_interval);
    assign o_high   = w_hcl;
    assign o_period = n_period;
    assign o_pole   = n_pole;
    assign o_scale  = QW'(r_pole_len) << FRAC_BITS;

    // Tick state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_last_rise <= '0;
            r_period    <= '0;
            r_high      <= '0;
            r_prev_pwm  <= 1'b0;
            r_prev_idx  <= 1'b0;
            r_pole      <= '0;
            r_timer     <= '0;
        end else if (i_accept) begin
            r_tick      <= r_tick + TIME_BITS'(1);
            r_last_rise <= n_last_rise;
            r_period    <= n_period;
            r_high      <= n_high;
            r_prev_pwm  <= i_pwm;
            r_prev_idx  <= i_idx;
            r_pole      <= n_pole;
            r_timer     <= o_report ? '0 : w_timer_inc;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RST;
            r_pole_len <= POLE_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_INTERVAL: r_interval <= i_cfg_data[INT_W-1:0];
                REG_POLE_LEN: r_pole_len <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/core/pept_arith.sv =====
// Shared arithmetic unit: one multiplier used twice, then a restoring
// divider stepping one quotient bit per cycle; holds the output beat.
// Depends on pept_pkg.
module pept_arith #(
    parameter int COUNT_BITS = 24,
    parameter int FRAC_BITS  = 4,
    parameter int TIME_BITS  = 32
) (
    input  logic                                 i_clk,
    input  pept_pkg::t_arith_ctl                 i_ctl,
    input  logic [TIME_BITS-1:0]                 i_high,
    input  logic [TIME_BITS-1:0]                 i_period,
    input  logic [COUNT_BITS-1:0]                i_pole,
    input  logic [pept_pkg::LEN_W+FRAC_BITS-1:0] i_scale,
    output pept_pkg::t_out_beat                  o_beat
);
    import pept_pkg::*;

    localparam int QW = LEN_W + FRAC_BITS;
    localparam int AW = ((TIME_BITS > COUNT_BITS) ? TIME_BITS : COUNT_BITS) + 1;
    localparam int PW = AW + QW + 1;
    localparam int NW = TIME_BITS + QW;

    // Snapshot of the tick that triggered the report
    logic [TIME_BITS-1:0]  r_h, r_d;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [QW-1:0]         r_scale;

    // Numerator, then remainder and quotient shifting in place
    logic [NW-1:0]         r_acc, n_acc;
    logic [POS_W-1:0]      r_cprod;
    t_out_beat             r_beat;

    logic signed [AW-1:0]  w_a;
    logic signed [QW:0]    w_b;
    logic signed [PW-1:0]  w_prod;
    logic [TIME_BITS:0]    w_trial, w_sub;
    logic                  w_ge;

    // Multiplier operand select: clamped high time, or signed pole count
    always_comb begin
        if (i_ctl.mul_h) begin
            w_a = signed'(AW'(r_h));
        end else begin
            w_a = AW'(signed'(r_cnt));
        end
        w_b    = signed'({1'b0, r_scale});
        w_prod = PW'(w_a * w_b);
    end

    // One restoring divide step
    always_comb begin
        w_trial = {r_acc[NW-1 -: TIME_BITS], r_acc[QW-1]};
        w_sub   = w_trial - {1'b0, r_d};
        w_ge    = (w_trial >= {1'b0, r_d});
        n_acc   = {w_ge ? w_sub[TIME_BITS-1:0] : w_trial[TIME_BITS-1:0],
                   r_acc[QW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_h     <= i_high;
            r_d     <= i_period;
            r_cnt   <= i_pole;
            r_scale <= i_scale;
        end
        if (i_ctl.mul_h) begin
            r_acc <= w_prod[NW-1:0];
        end else if (i_ctl.div_step) begin
            r_acc <= n_acc;
        end
        if (i_ctl.mul_c) begin
            r_cprod <= POS_W'(w_prod);
        end
        // Output beat; a zero period gives an invalid report at position zero
        if (i_ctl.out_load) begin
            r_beat.position       <= (r_d == '0) ? '0
                                     : signed'(POS_W'(r_acc[QW-1:0]) + r_cprod);
            r_beat.pole_total     <= POLE_W'(signed'(r_cnt));
            r_beat.position_valid <= (r_d != '0);
        end
    end

    assign o_beat = r_beat;

endmodule

// ===== rtl/core/pept_ctrl.sv =====
// Report sequencer: steps the arithmetic unit through multiply, multiply,
// divide and output load; owns the channel handshakes. Depends on pept_pkg.
module pept_ctrl #(
    parameter int FRAC_BITS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_report,
    input  logic                 i_out_stall,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output pept_pkg::t_arith_ctl o_ctl
);
    import pept_pkg::*;

    localparam int QW     = LEN_W + FRAC_BITS;
    localparam int STEP_W = $clog2(QW);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    logic              w_out_free, w_last_step;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_last_step = (r_step == STEP_W'(QW - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_accept && i_report) n_state = ST_MUL_H;
            ST_MUL_H: n_state = ST_MUL_C;
            ST_MUL_C: n_state = ST_DIV;
            ST_DIV:   if (w_last_step) n_state = ST_DONE;
            ST_DONE:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Unit controls
    always_comb begin
        o_ctl          = '0;
        o_in_stall     = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_ctl.load = i_accept && i_report;
            end
            ST_MUL_H: o_ctl.mul_h    = 1'b1;
            ST_MUL_C: o_ctl.mul_c    = 1'b1;
            ST_DIV:   o_ctl.div_step = 1'b1;
            ST_DONE:  o_ctl.out_load = w_out_free;
            default:  o_in_stall     = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= (r_state == ST_DIV) ? r_step + STEP_W'(1) : '0;
            if (o_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/pwm_encoder_position_tracker_top.sv =====
// PWM encoder position tracker, top level.
// Instantiates pept_track, pept_ctrl and pept_arith; depends on pept_pkg.
//
// Usage:
//   Input channel: one beat per time tick carrying the sampled PWM and index
//   pin levels. A tick that does not fall on a report is taken without a
//   stall, so such ticks can stream back to back.
//   A tick that completes a report interval starts the report engine: two
//   passes through the shared multiplier, then 12+FRAC_BITS divide steps of
//   one quotient bit each (16 at defaults). o_in_stall stays high after such
//   a tick through the multiply, divide and done states, and the report
//   beat shows on o_out_valid once the output register is free, after the
//   divide steps.
//   Output channel: a registered beat with position (1/2^FRAC_BITS units),
//   pole count and a valid flag. While the receiver stalls the beat holds;
//   the next report may still be computed and then waits, with the input
//   stalled, until the held beat is taken.
//   Reset (synchronous, active low) clears all tick state, the pole counter
//   and report timer, and restores the report interval and pole length.
//   Configuration writes take effect at the write edge; write only when idle.
module pwm_encoder_position_tracker_top #(
    parameter int COUNT_BITS = 24,
    parameter int FRAC_BITS  = 4,
    parameter int TIME_BITS  = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  pept_pkg::t_in_beat         i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output pept_pkg::t_out_beat        o_out_data,
    input  logic                       i_cfg_we,
    input  logic [pept_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [pept_pkg::CFG_W-1:0] i_cfg_data
);
    import pept_pkg::*;

    localparam int QW = LEN_W + FRAC_BITS;

    logic                  w_accept, w_report;
    logic [TIME_BITS-1:0]  w_high, w_period;
    logic [COUNT_BITS-1:0] w_pole;
    logic [QW-1:0]         w_scale;
    t_arith_ctl            w_ctl;

    assign w_accept = i_in_valid && !o_in_stall;

    pept_track #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_pwm      (i_in_data.pwm_level),
        .i_idx      (i_in_data.index_level),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_report   (w_report),
        .o_high     (w_high),
        .o_period   (w_period),
        .o_pole     (w_pole),
        .o_scale    (w_scale)
    );

    pept_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_report    (w_report),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_ctl       (w_ctl)
    );

    pept_arith #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_arith (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_high   (w_high),
        .i_period (w_period),
        .i_pole   (w_pole),
        .i_scale  (w_scale),
        .o_beat   (o_out_data)
    );

endmodule

// ===== rtl/core/pept_checker.sv =====
// Port-level checks for the position tracker top, bound in below.
// Depends on pept_pkg and pwm_encoder_position_tracker_top.
module pept_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input pept_pkg::t_out_beat        o_out_data
);
    import pept_pkg::*;

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // An invalid report carries position zero
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.position_valid |-> o_out_data.position == '0)
        else $error("invalid report with nonzero position");

    // A new report only appears after the engine held off the input
    a_report_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("report without a busy period");

    // A report computation keeps the input stalled in the cycle after the stall rises
    a_busy_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |=> o_in_stall)
        else $error("input stall lasted a single cycle");

endmodule

bind pwm_encoder_position_tracker_top pept_checker u_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for pwm_encoder_position_tracker_top.
// Holds a position report scoreboard with its own tick predictor; needs only pept_pkg and the RTL.
// Stimulus is a short directed edge sequence, then random PWM/index waveforms under several settings.
module tb_top;
    import pept_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 40;

    // Directed opening: {pwm, index} per tick
    localparam logic [1:0] OPENING [0:19] = '{
        2'b11, 2'b11, 2'b00, 2'b00, 2'b10, 2'b11, 2'b00, 2'b00, 2'b00, 2'b11,
        2'b00, 2'b10, 2'b10, 2'b10, 2'b10, 2'b10, 2'b10, 2'b01, 2'b00, 2'b00
    };

    // Predicts position reports tick by tick and checks the ones that come out
    class position_report_board;
        logic [INT_W-1:0]  interval;
        logic [LEN_W-1:0]  pole_len;
        logic [31:0]       tick_now;
        logic [31:0]       rise_stamp;
        logic [31:0]       period;
        logic [31:0]       high;
        logic              pwm_q;
        logic              idx_q;
        logic [POLE_W-1:0] poles;
        logic [INT_W-1:0]  timer;
        t_out_beat         expected_reports[$];
        int                mismatches;
        int                ticks_taken;
        int                reports_checked;

        function new();
            interval = INTERVAL_RST;
            pole_len = POLE_LEN_RST;
            tick_now = '0;
            rise_stamp = '0;
            period = '0;
            high = '0;
            pwm_q = 1'b0;
            idx_q = 1'b0;
            poles = '0;
            timer = '0;
            mismatches = 0;
            ticks_taken = 0;
            reports_checked = 0;
        endfunction

        function void flag(string what);
            mismatches++;
            $display("MISMATCH: %s", what);
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_INTERVAL: interval = val[INT_W-1:0];
                REG_POLE_LEN: pole_len = val[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] clamped_high();
            return (high < period) ? high : period;
        endfunction

        // One accepted tick: edge timing, pole counting, and a report when the timer expires
        function void note_tick(t_in_beat b);
            logic [31:0]        now;
            logic [32:0]        twice_high;
            logic [INT_W-1:0]   nxt;
            logic [63:0]        cnt;
            logic [63:0]        scale;
            logic [63:0]        frac;
            logic [63:0]        pos;
            t_out_beat          r;
            ticks_taken++;
            now = tick_now;
            if (b.pwm_level && !pwm_q) begin
                period = now - rise_stamp;
                rise_stamp = now;
            end else if (!b.pwm_level && pwm_q) begin
                high = now - rise_stamp;
            end
            pwm_q = b.pwm_level;

            // index edge sees this tick's period and high time
            if (b.index_level && !idx_q) begin
                twice_high = {clamped_high(), 1'b0};
                if (twice_high < {1'b0, period}) poles = poles + 1'b1;
                else poles = poles - 1'b1;
            end
            idx_q = b.index_level;
            tick_now = now + 1;

            nxt = timer + 1'b1;
            if (nxt < interval) begin
                timer = nxt;
                return;
            end
            timer = '0;

            cnt = {{(64-POLE_W){poles[POLE_W-1]}}, poles};
            scale = {48'b0, pole_len, 4'b0};
            pos = '0;
            r.position_valid = 1'b0;
            if (period != 0) begin
                frac = ({32'b0, clamped_high()} * scale) / {32'b0, period};
                pos = frac + scale * cnt;
                r.position_valid = 1'b1;
            end
            r.position = pos[POS_W-1:0];
            r.pole_total = poles;
            expected_reports.push_back(r);
        endfunction

        function void check_report(t_out_beat got);
            t_out_beat want;
            reports_checked++;
            if (expected_reports.size() == 0) begin
                flag($sformatf("report %0d arrived with none pending", reports_checked));
                return;
            end
            want = expected_reports.pop_front();
            if (got.position !== want.position)
                flag($sformatf("report %0d position got %0d want %0d",
                               reports_checked, got.position, want.position));
            if (got.pole_total !== want.pole_total)
                flag($sformatf("report %0d pole_total got %0d want %0d",
                               reports_checked, got.pole_total, want.pole_total));
            if (got.position_valid !== want.position_valid)
                flag($sformatf("report %0d position_valid got %b want %b",
                               reports_checked, got.position_valid, want.position_valid));
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void flush_leftovers();
            while (expected_reports.size() > 0) begin
                void'(expected_reports.pop_front());
                flag("report expected but never delivered");
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_beat             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_beat            o_out_data;
    logic                 i_cfg_we = 1'b0;
    logic [IDX_W-1:0]     i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    position_report_board board;
    int  cycles = 0;
    int  settings_run = 0;
    bit  no_idle = 1'b0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    int  stall_left = 0;
    bit  idx_lvl = 1'b0;

    pwm_encoder_position_tracker_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("pwm_encoder_position_tracker_top verification failed");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Receiver: random stall bursts, plus one long hold on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = ($urandom_range(3) == 0) ? pick_gap() : 0;
        end
    end

    // Beat monitor on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) board.note_tick(i_in_data);
            if (o_out_valid && !i_out_stall) board.check_report(o_out_data);
        end
    end

    task automatic send_tick(input logic pwm, input logic idx);
        t_in_beat b;
        int       gap;
        b.pwm_level = pwm;
        b.index_level = idx;
        i_in_valid <= 1'b1;
        i_in_data <= b;
        do @(posedge i_clk); while (o_in_stall);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Let every pending report out, then give the engine time to go quiet
    task automatic drain();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (board.pending() > 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random ticks: mostly clean PWM waveforms of random period and duty, some pin noise
    task automatic run_ticks(input int n_items);
        int sent;
        int per;
        int hi;
        int reps;
        int k;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) < 8) begin
                per = $urandom_range(2, 40);
                hi = $urandom_range(0, per);
                reps = $urandom_range(1, 4);
                repeat (reps) begin
                    for (k = 0; k < per && sent < n_items; k++) begin
                        if ($urandom_range(11) == 0) idx_lvl = ~idx_lvl;
                        send_tick(k < hi, idx_lvl);
                        sent++;
                    end
                end
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    idx_lvl = $urandom_range(1);
                    send_tick($urandom_range(1), idx_lvl);
                    sent++;
                end
            end
        end
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] interval, input logic [CFG_W-1:0] len_data,
                             input int n_items, input bit quiet, input bit squeeze);
        drain();
        write_reg(REG_INTERVAL, interval);
        write_reg(REG_POLE_LEN, len_data);
        settings_run++;
        no_idle = quiet;
        if (squeeze) hold_req = 1'b1;
        run_ticks(n_items);
        no_idle = 1'b0;
    endtask

    initial begin
        int i;
        board = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: first high sample, zero period index edge, same tick edges, clamping
        write_reg(REG_INTERVAL, 24'd1);
        write_reg(REG_POLE_LEN, 24'd4095);
        settings_run++;
        for (i = 0; i < 20; i++) send_tick(OPENING[i][1], OPENING[i][0]);
        idx_lvl = 1'b0;

        // Random phases; upper data bits on the pole length write are junk
        run_phase(24'd1, 24'd1, 120, 1'b0, 1'b1);
        run_phase(24'($urandom_range(2, 16)),
                  24'($urandom_range(1, 4095)) | (24'($urandom) & 24'hFFF000), 200, 1'b0, 1'b0);
        run_phase(24'd0, 24'd0, 80, 1'b0, 1'b0);
        run_phase(24'hFFFFFF, 24'd4095, 60, 1'b0, 1'b0);
        run_phase(24'($urandom_range(3, 40)), 24'd2000, 200, 1'b1, 1'b0);
        run_phase(24'd7, 24'($urandom_range(1, 4095)) | 24'hFFF000, 240, 1'b0, 1'b0);

        drain();
        board.flush_leftovers();
        $display("Covered %0d ticks and %0d position reports over %0d register settings.",
                 board.ticks_taken, board.reports_checked, settings_run);
        if (board.mismatches == 0) begin
            $display("pwm_encoder_position_tracker_top verification clean");
        end else begin
            $display("%0d mismatches", board.mismatches);
            $display("pwm_encoder_position_tracker_top verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/pept_pkg.sv
rtl/core/pept_track.sv
rtl/core/pept_arith.sv
rtl/core/pept_ctrl.sv
rtl/core/pwm_encoder_position_tracker_top.sv
rtl/core/pept_checker.sv
tb/tb_top.sv
